// ----- rtl/jrs_pkg.sv -----
// Shared types, constants and tables for the jog ramp sequencer.
// No dependencies; used by jrs_vel, jrs_core and jog_ramp_sequencer.
package jrs_pkg;

  // Ramp length and position width
  localparam int RAMP_STEPS = 25;
  localparam int POS_WIDTH  = 32;

  localparam int STEP_W   = 5;
  localparam int AXIS_W   = 3;
  localparam int VEL_W    = 20;
  localparam int GAIN_W   = 17;
  localparam int OFF_W    = 16;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 1;
  localparam int TAB_LAST = 25;
  localparam int STEP_CNT = 32;

  // Stream widths (fields packed from bit 0, padded to whole bytes)
  localparam int IN_W        = AXIS_W + 2 * POS_WIDTH + 2;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = STATUS_W + 1 + AXIS_W + POS_WIDTH + VEL_W + 1;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // Command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_IDLE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_AGAIN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd2;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_START_VEL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VEL   = 1'd1;
  localparam logic [VEL_W-1:0] START_VEL_RST = 20'd200;
  localparam logic [VEL_W-1:0] MAX_VEL_RST   = 20'd10000;

  // round(65536 * 10^(k/25 - 1)), k = 0..25
  typedef logic [0:TAB_LAST][GAIN_W-1:0] gain_list_t;
  localparam gain_list_t RAMP_GAIN = {
    17'd6554,  17'd7186,  17'd7879,  17'd8639,  17'd9473,  17'd10387,
    17'd11389, 17'd12488, 17'd13692, 17'd15013, 17'd16462, 17'd18050,
    17'd19792, 17'd21701, 17'd23795, 17'd26090, 17'd28608, 17'd31368,
    17'd34394, 17'd37712, 17'd41350, 17'd45340, 17'd49714, 17'd54510,
    17'd59770, 17'd65536
  };

  typedef logic [STEP_CNT-1:0][GAIN_W-1:0] gain_tab_t;
  typedef logic [STEP_CNT-1:0][OFF_W-1:0]  off_tab_t;

  // Gain per ramp step: table index round(s*25/RAMP_STEPS), capped at the end
  function automatic gain_tab_t build_gain_tab();
    gain_tab_t tab;
    int idx;
    for (int k = 0; k < STEP_CNT; k++) begin
      idx = (k * 50 + RAMP_STEPS) / (2 * RAMP_STEPS);
      if (idx > TAB_LAST) idx = TAB_LAST;
      tab[k] = RAMP_GAIN[idx];
    end
    return tab;
  endfunction

  // Offset per ramp step: 10 + 40*s*(s+1) um
  function automatic off_tab_t build_off_tab();
    off_tab_t tab;
    for (int k = 0; k < STEP_CNT; k++) begin
      tab[k] = OFF_W'(10 + 40 * k * (k + 1));
    end
    return tab;
  endfunction

  localparam gain_tab_t GAIN_BY_STEP = build_gain_tab();
  localparam off_tab_t  OFF_BY_STEP  = build_off_tab();

  // One input item
  typedef struct packed {
    logic                        cmd;
    logic [AXIS_W-1:0]           axis_sel;
    logic signed [POS_WIDTH-1:0] origin_um;
    logic signed [POS_WIDTH-1:0] goal_um;
    logic                        planner_full;
    logic                        runtime_busy;
  } item_t;

  // One result item
  typedef struct packed {
    logic [STATUS_W-1:0]         status;
    logic                        move_valid;
    logic [AXIS_W-1:0]           move_axis;
    logic signed [POS_WIDTH-1:0] move_target;
    logic [VEL_W-1:0]            move_velocity;
    logic                        jog_done;
  } result_t;

endpackage

// ----- rtl/jrs_vel.sv -----
// Ramp velocity: start + (max - start) * gain(step), rounded half up.
// Depends on jrs_pkg for widths and the gain table.
module jrs_vel (
  input  logic [jrs_pkg::VEL_W-1:0]  start_velocity,
  input  logic [jrs_pkg::VEL_W-1:0]  max_velocity,
  input  logic [jrs_pkg::STEP_W-1:0] step,
  output logic [jrs_pkg::VEL_W-1:0]  velocity
);

  localparam int D_W = jrs_pkg::VEL_W + 1;
  localparam int P_W = D_W + jrs_pkg::GAIN_W + 1;
  localparam int R_W = P_W - 16;

  logic signed [D_W-1:0]                 diff;
  logic signed [jrs_pkg::GAIN_W:0]       gain;
  logic signed [P_W-1:0]                 prod;
  logic signed [P_W-1:0]                 prod_rnd;
  logic signed [R_W-1:0]                 scaled;
  logic signed [R_W-1:0]                 sum;

  // Signed difference times Q16 gain
  assign diff = $signed({1'b0, max_velocity}) - $signed({1'b0, start_velocity});
  assign gain = $signed({1'b0, jrs_pkg::GAIN_BY_STEP[step]});
  assign prod = diff * gain;

  // Round to nearest, halves toward +infinity (floor of p + 0.5)
  assign prod_rnd = prod + P_W'(32768);
  assign scaled   = prod_rnd[P_W-1:16];

  // Add back the start feed and keep the low bits
  assign sum      = $signed(R_W'(start_velocity)) + scaled;
  assign velocity = sum[jrs_pkg::VEL_W-1:0];

endmodule

// ----- rtl/jrs_core.sv -----
// Phase machine and move generation of the jog ramp sequencer.
// Depends on jrs_pkg and jrs_vel; state advances on each item handed over.
module jrs_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  jrs_pkg::item_t             item,
  input  logic [jrs_pkg::VEL_W-1:0]  start_velocity,
  input  logic [jrs_pkg::VEL_W-1:0]  max_velocity,
  output jrs_pkg::result_t           res
);

  localparam int PW = jrs_pkg::POS_WIDTH;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_START,
    PH_RAMP,
    PH_FINAL
  } phase_t;

  phase_t                     phase, phase_next;
  logic [jrs_pkg::STEP_W-1:0] ramp_step, ramp_step_next;
  logic [jrs_pkg::AXIS_W-1:0] jog_axis;
  logic signed [PW-1:0]       base_pos;
  logic signed [PW-1:0]       end_pos;

  logic                       up;
  logic [PW-1:0]              span;
  logic [PW-1:0]              off_step;
  logic [PW-1:0]              off;
  logic                       last;
  logic [jrs_pkg::VEL_W-1:0]  ramp_vel;

  // Distance and clamped offset for the current step
  assign up       = (base_pos <= end_pos);
  assign span     = up ? PW'(end_pos - base_pos) : PW'(base_pos - end_pos);
  assign off_step = PW'(jrs_pkg::OFF_BY_STEP[ramp_step]);
  assign last     = (off_step >= span) ||
                    (ramp_step >= jrs_pkg::STEP_W'(jrs_pkg::RAMP_STEPS));
  assign off      = last ? span : off_step;

  jrs_vel u_vel (
    .start_velocity (start_velocity),
    .max_velocity   (max_velocity),
    .step           (ramp_step),
    .velocity       (ramp_vel)
  );

  // Result and next phase for the item at hand
  always_comb begin
    res            = '0;
    phase_next     = phase;
    ramp_step_next = ramp_step;
    if (item.cmd == jrs_pkg::CMD_START) begin
      res.status     = jrs_pkg::ST_DONE;
      phase_next     = PH_START;
      ramp_step_next = '0;
    end else begin
      case (phase)
        PH_IDLE: begin
          res.status = jrs_pkg::ST_IDLE;
        end
        PH_START: begin
          res.status = jrs_pkg::ST_AGAIN;
          phase_next = PH_RAMP;
        end
        PH_RAMP: begin
          res.status = jrs_pkg::ST_AGAIN;
          if (!item.planner_full) begin
            res.move_valid    = 1'b1;
            res.move_axis     = jog_axis;
            res.move_target   = up ? base_pos + $signed(off) : base_pos - $signed(off);
            res.move_velocity = ramp_vel;
            ramp_step_next    = ramp_step + 1'b1;
            if (last) phase_next = PH_FINAL;
          end
        end
        PH_FINAL: begin
          if (item.runtime_busy) begin
            res.status = jrs_pkg::ST_AGAIN;
          end else begin
            res.status   = jrs_pkg::ST_DONE;
            res.jog_done = 1'b1;
            phase_next   = PH_IDLE;
          end
        end
        default: begin
          res.status = jrs_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Hold jog state; latch a new jog on start
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      ramp_step <= '0;
      jog_axis  <= '0;
      base_pos  <= '0;
      end_pos   <= '0;
    end else if (advance) begin
      phase     <= phase_next;
      ramp_step <= ramp_step_next;
      if (item.cmd == jrs_pkg::CMD_START) begin
        jog_axis <= item.axis_sel;
        base_pos <= item.origin_um;
        end_pos  <= item.goal_um;
      end
    end
  end

  a_move_only_in_ramp: assert property (@(posedge clk) disable iff (rst)
    advance && res.move_valid |-> phase == PH_RAMP)
    else $error("move issued outside ramp phase");

  a_done_returns_idle: assert property (@(posedge clk) disable iff (rst)
    advance && res.jog_done |=> phase == PH_IDLE)
    else $error("jog done without return to idle");

  a_start_arms: assert property (@(posedge clk) disable iff (rst)
    advance && item.cmd == jrs_pkg::CMD_START |=> phase == PH_START && ramp_step == '0)
    else $error("start item did not arm the jog");

  a_step_bounded: assert property (@(posedge clk) disable iff (rst)
    phase == PH_RAMP |-> ramp_step <= jrs_pkg::STEP_W'(jrs_pkg::RAMP_STEPS))
    else $error("ramp step ran past the last move");

endmodule

// ----- rtl/jog_ramp_sequencer.sv -----
// Top level of the jog ramp sequencer: stream ports, input and result registers,
// configuration registers. Depends on jrs_pkg and jrs_core.
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid / s_tready  s_tuser = cmd, s_tdata = start/tick fields
//  m_*       out  m_tvalid / m_tready  m_tdata = status and move fields
//  cfg_*     in   cfg_we               cfg_addr = register, cfg_data = value
//
// One result item per input item, one item per cycle sustained while m_tready
// stays high; each item passes the input register, then the result register,
// and m_tvalid rises once it reaches the result register.
// The ramp step, phase and velocity math sit between those two registers.
// Reset (rst, synchronous) empties both registers, idles the phase machine
// and loads the default feed rates. A stall on m_tready holds the result and
// lets one more item wait in the input register before s_tready drops.
module jog_ramp_sequencer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [2:0] axis_sel, [PW+2:3] origin_um, [2PW+2:PW+3] goal_um,
  // [2PW+3] planner_full, [2PW+4] runtime_busy, zero pad above
  input  logic [jrs_pkg::IN_TDATA_W-1:0]      s_tdata,
  // [0] cmd
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [1:0] status, [2] move_valid, [5:3] move_axis, [PW+5:6] move_target,
  // [PW+25:PW+6] move_velocity, [PW+26] jog_done, zero pad above
  output logic [jrs_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic                                cfg_we,
  input  logic [jrs_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [jrs_pkg::VEL_W-1:0]           cfg_data
);

  localparam int PW = jrs_pkg::POS_WIDTH;
  localparam int AW = jrs_pkg::AXIS_W;

  logic                       in_valid;
  jrs_pkg::item_t             in_item;
  jrs_pkg::item_t             s_item;
  logic                       out_valid;
  jrs_pkg::result_t           out_res;
  jrs_pkg::result_t           res;
  logic                       advance;
  logic [jrs_pkg::VEL_W-1:0]  start_velocity;
  logic [jrs_pkg::VEL_W-1:0]  max_velocity;

  // Unpack the incoming item
  always_comb begin
    s_item.cmd          = s_tuser;
    s_item.axis_sel     = s_tdata[AW-1:0];
    s_item.origin_um    = s_tdata[AW +: PW];
    s_item.goal_um      = s_tdata[AW+PW +: PW];
    s_item.planner_full = s_tdata[AW+2*PW];
    s_item.runtime_busy = s_tdata[AW+2*PW+1];
  end

  // Move an item into the result register when it is free or being taken
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (s_tvalid && s_tready) in_item <= s_item;
  end

  jrs_core u_core (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .item           (in_item),
    .start_velocity (start_velocity),
    .max_velocity   (max_velocity),
    .res            (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (advance) out_res <= res;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = jrs_pkg::OUT_TDATA_W'({out_res.jog_done, out_res.move_velocity,
                                           out_res.move_target, out_res.move_axis,
                                           out_res.move_valid, out_res.status});

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_velocity <= jrs_pkg::START_VEL_RST;
      max_velocity   <= jrs_pkg::MAX_VEL_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        jrs_pkg::REG_START_VEL: start_velocity <= cfg_data;
        jrs_pkg::REG_MAX_VEL:   max_velocity   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
